// ===== rtl/pirl_pkg.sv =====
// Package for the positional insert/remove list.
// Holds sizes, operation and status codes, beat payload types and the
// command that the controller broadcasts along the row of cells.
`default_nettype none

package pirl_pkg;

	localparam int DEPTH      = 16;
	localparam int WORD_WIDTH = 32;
	localparam int POS_W      = 5;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;

	// Operation codes carried in the op field.
	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_REMOVE = 3'd1,
		OP_POP    = 3'd2,
		OP_SHIFT  = 3'd3,
		OP_READ   = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Input beat.
	typedef struct packed {
		logic [2:0]            op;
		logic [POS_W-1:0]      position;
		logic [WORD_WIDTH-1:0] value;
	} in_t;

	// Output beat.
	typedef struct packed {
		logic [WORD_WIDTH-1:0] read_value;
		logic [CNT_W-1:0]      count_now;
		status_t               status;
	} out_t;

	// Command broadcast to every cell for one accepted beat.
	typedef struct packed {
		logic                  ins;
		logic                  del;
		logic [IDX_W-1:0]      pos;
		logic [CNT_W-1:0]      cnt;
		logic [WORD_WIDTH-1:0] value;
	} cell_cmd_t;

	// Read request and result fields from the controller.
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic [CNT_W-1:0] count_now;
		status_t          status;
	} ctrl_res_t;

endpackage

`default_nettype wire

// ===== rtl/positional_insert_remove_list.sv =====
// Positional insert/remove list: an ordered row of DEPTH word cells.
// Each accepted input beat yields a registered output beat in the next cycle.
// Throughput: one beat per cycle unless out_ready stalls the output; every
// cell picks its own, left or right neighbor word, and the output register
// refills while drained. Reset clears the count and the output valid; cell
// words stay unknown until written and are never read before that.
// Depends on pirl_pkg, pirl_ctrl and pirl_cell.
`default_nettype none

module positional_insert_remove_list
	import pirl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	logic                  accept;
	cell_cmd_t             cmd;
	ctrl_res_t             res;
	logic [WORD_WIDTH-1:0] cell_data [DEPTH];
	logic                  out_valid_q;
	out_t                  out_q;

	// A new beat enters whenever the output register is free or draining.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	pirl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (in_data),
		.cmd    (cmd),
		.res    (res)
	);

	// Row of cells; the ends see zero where there is no neighbor.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_WIDTH-1:0] left_w;
		logic [WORD_WIDTH-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		pirl_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(i)),
			.cmd   (cmd),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i])
		);
	end

	// Output beat valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// Output beat payload, read from the cell the controller selects.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.read_value <= res.rd_en ? cell_data[res.rd_idx] : '0;
			out_q.count_now  <= res.count_now;
			out_q.status     <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== rtl/pirl_cell.sv =====
// One storage cell of the list row.
// Depends on pirl_pkg for the broadcast command type and word width.
`default_nettype none

module pirl_cell
	import pirl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic [IDX_W-1:0]      idx,
	input  wire cell_cmd_t             cmd,
	input  wire logic [WORD_WIDTH-1:0] left,
	input  wire logic [WORD_WIDTH-1:0] right,
	output logic [WORD_WIDTH-1:0]      data
);

	logic [WORD_WIDTH-1:0] data_q;
	logic [CNT_W-1:0]      idx_ext;
	logic                  take_left;
	logic                  take_right;
	logic                  load;

	// Decide from the broadcast command whether this cell moves.
	always_comb begin
		idx_ext    = CNT_W'(idx);
		load       = cmd.ins && (idx == cmd.pos);
		take_left  = cmd.ins && (idx > cmd.pos) && (idx_ext <= cmd.cnt);
		take_right = cmd.del && (idx >= cmd.pos) && ((idx_ext + CNT_W'(1)) < cmd.cnt);
	end

	// The stored word takes the new value or a neighbor's word, or holds.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= cmd.value;
		end else if (take_left) begin
			data_q <= left;
		end else if (take_right) begin
			data_q <= right;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ===== rtl/pirl_ctrl.sv =====
// Controller of the list: count register, clamping, status and cell command.
// Depends on pirl_pkg for codes, sizes and the command and result types.
`default_nettype none

module pirl_ctrl
	import pirl_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  accept,
	input  wire in_t   item,
	output cell_cmd_t  cmd,
	output ctrl_res_t  res
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] pos_ext;
	logic [CNT_W-1:0] last;
	logic             ins;
	logic             del;

	// Decode the operation against the current count.
	always_comb begin
		cnt_ext       = CMP_W'(count_q);
		pos_ext       = CMP_W'(item.position);
		last          = count_q - CNT_W'(1);
		count_d       = count_q;
		ins           = 1'b0;
		del           = 1'b0;
		cmd.pos       = item.position[IDX_W-1:0];
		cmd.cnt       = count_q;
		cmd.value     = item.value;
		res.rd_en     = 1'b0;
		res.rd_idx    = item.position[IDX_W-1:0];
		res.status    = ST_OK;
		case (item.op)
			OP_INSERT: begin
				if (count_q == CNT_W'(DEPTH)) begin
					res.status = ST_FULL;
				end else begin
					ins     = 1'b1;
					count_d = count_q + CNT_W'(1);
					if (pos_ext > cnt_ext) begin
						cmd.pos = count_q[IDX_W-1:0];
					end
				end
			end
			OP_REMOVE: begin
				if (count_q == '0) begin
					res.status = ST_EMPTY;
				end else begin
					del     = 1'b1;
					count_d = last;
					if (pos_ext >= cnt_ext) begin
						cmd.pos = last[IDX_W-1:0];
					end
				end
			end
			OP_POP: begin
				if (count_q == '0) begin
					res.status = ST_EMPTY;
				end else begin
					res.rd_en  = 1'b1;
					res.rd_idx = last[IDX_W-1:0];
					count_d    = last;
				end
			end
			OP_SHIFT: begin
				if (count_q == '0) begin
					res.status = ST_EMPTY;
				end else begin
					res.rd_en  = 1'b1;
					res.rd_idx = '0;
					del        = 1'b1;
					cmd.pos    = '0;
					count_d    = last;
				end
			end
			OP_READ: begin
				if (pos_ext >= cnt_ext) begin
					res.status = ST_RANGE;
				end else begin
					res.rd_en = 1'b1;
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
		cmd.ins       = accept && ins;
		cmd.del       = accept && del;
		res.count_now = count_d;
	end

	// Count of valid entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pirl_checker.sv =====
// Port-level checks for the positional insert/remove list, bound to the top.
// Depends on pirl_pkg for sizes and status codes.
`default_nettype none

module pirl_checker
	import pirl_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire out_t out_data
);

	// A stalled output beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// The count never passes the list depth.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.count_now <= CNT_W'(DEPTH))
		else $error("count above depth");

	// A rejected insert means the list is full.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_FULL |-> out_data.count_now == CNT_W'(DEPTH))
		else $error("full status with list not full");

	// A rejected removal means the list is empty.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_EMPTY |-> out_data.count_now == '0)
		else $error("empty status with list not empty");

	// Any error returns a zero word.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.read_value == '0)
		else $error("nonzero word with error status");

endmodule

bind positional_insert_remove_list pirl_checker u_pirl_checker (.*);

`default_nettype wire

// ===== tb/list_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the positional insert/remove list: keeps its own copy of the
// list, predicts one result per request beat and compares the output beats.
// Depends on pirl_pkg for the beat types and the operation and status codes.

module list_checker
	import pirl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  in_t  in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  out_t out_data,
	output int   errors,
	output int   pending,
	output int   compared,
	output int   rejects
);

	// Shadow copy of the list contents and its fill level.
	logic [WORD_WIDTH-1:0] shadow_row [DEPTH];
	int                    fill;
	out_t                  awaited_results [$];
	out_t                  want;

	// Delete the entry at idx and move the later entries down one place.
	function automatic void close_row_gap(int idx);
		int i;
		for (i = idx; i + 1 < fill; i++) begin
			shadow_row[i] = shadow_row[i + 1];
		end
		fill--;
	endfunction

	// Apply one request beat to the shadow list and return the result it yields.
	function automatic out_t next_list_result(in_t b);
		out_t r;
		int   p;
		int   i;
		r = '0;
		r.status = ST_OK;
		p = b.position;
		case (b.op)
			OP_INSERT: begin
				if (fill >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					if (p > fill)
						p = fill;
					for (i = fill; i > p; i--) begin
						shadow_row[i] = shadow_row[i - 1];
					end
					shadow_row[p] = b.value;
					fill++;
				end
			end
			OP_REMOVE: begin
				if (fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (p > fill - 1)
						p = fill - 1;
					close_row_gap(p);
				end
			end
			OP_POP: begin
				if (fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.read_value = shadow_row[fill - 1];
					fill--;
				end
			end
			OP_SHIFT: begin
				if (fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.read_value = shadow_row[0];
					close_row_gap(0);
				end
			end
			OP_READ: begin
				if (p >= fill)
					r.status = ST_RANGE;
				else
					r.read_value = shadow_row[p];
			end
			OP_CLEAR: begin
				fill = 0;
			end
			default: begin
			end
		endcase
		r.count_now = CNT_W'(fill);
		return r;
	endfunction

	// Predict on each accepted request beat, then check each accepted result beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			awaited_results.delete();
			errors = 0;
			pending = 0;
			compared = 0;
			rejects = 0;
		end else begin
			if (in_valid && in_ready)
				awaited_results.push_back(next_list_result(in_data));
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("list_checker: result beat with no request outstanding");
					errors++;
				end else begin
					want = awaited_results.pop_front();
					compared++;
					if (want.status != ST_OK)
						rejects++;
					if (out_data.read_value !== want.read_value) begin
						$error("list_checker: read_value expected %h got %h",
							want.read_value, out_data.read_value);
						errors++;
					end
					if (out_data.count_now !== want.count_now) begin
						$error("list_checker: count_now expected %0d got %0d",
							want.count_now, out_data.count_now);
						errors++;
					end
					if (out_data.status !== want.status) begin
						$error("list_checker: status expected %0d got %0d",
							want.status, out_data.status);
						errors++;
					end
				end
			end
			pending = awaited_results.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the list testbench: clock, reset, request and back-pressure stimulus,
// and the verdict. Depends on pirl_pkg, the list RTL and list_checker.

module tb_top;
	import pirl_pkg::*;

	// Op codes that the block treats as no operation.
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int RANDOM_ITEMS = 1550;
	localparam int CALM_TAIL    = 150;
	localparam int CYCLE_LIMIT  = 400000;

	logic clk;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	int errors;
	int pending;
	int compared;
	int rejects;
	int sent;
	int cycles;
	bit idle_on;
	bit calm;

	positional_insert_remove_list dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	list_checker list_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.errors    (errors),
		.pending   (pending),
		.compared  (compared),
		.rejects   (rejects)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle counter that ends a hung run.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top: errors");
		$finish;
	end

	// Output back-pressure: random stall bursts while idling is enabled and the run is not in its calm tail.
	initial begin
		forever begin
			@(posedge clk);
			if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Present one request beat, maybe after an idle burst, and hold it until taken.
	task automatic send_beat(input logic [2:0] op, input logic [POS_W-1:0] pos,
			input logic [WORD_WIDTH-1:0] val);
		in_t b;
		b.op = op;
		b.position = pos;
		b.value = val;
		if (idle_on && !calm && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// Word with extra weight on all zeros and all ones.
	function automatic logic [WORD_WIDTH-1:0] random_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	// Operation mix: growing phases favor inserts, shrinking phases favor removals.
	function automatic logic [2:0] pick_op(bit growing);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
		if (r < 3)
			return OP_CLEAR;
		if (growing) begin
			if (r < 58)
				return OP_INSERT;
			if (r < 64)
				return OP_REMOVE;
			if (r < 68)
				return OP_POP;
			if (r < 72)
				return OP_SHIFT;
		end else begin
			if (r < 18)
				return OP_INSERT;
			if (r < 40)
				return OP_REMOVE;
			if (r < 52)
				return OP_POP;
			if (r < 64)
				return OP_SHIFT;
		end
		return OP_READ;
	endfunction

	// Reset, directed cases, random traffic, drain and verdict.
	initial begin
		int          i;
		int          counted;
		bit          growing;
		logic [2:0]  op;
		logic [POS_W-1:0] pos;
		sent = 0;
		idle_on = 1'b1;
		calm = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Removals, read and a spare op on the empty list.
		send_beat(OP_POP, '0, '0);
		send_beat(OP_SHIFT, '0, '0);
		send_beat(OP_REMOVE, '1, '0);
		send_beat(OP_READ, '0, '0);
		send_beat(OP_SPARE_HI, '1, '1);

		// Fill the list with appends past the end, prepends and middle inserts.
		for (i = 0; i < DEPTH; i++) begin
			pos = (i % 3 == 0) ? '1 : (i % 3 == 1) ? '0 : POS_W'(i / 2);
			send_beat(OP_INSERT, pos, (i == 0) ? '1 : (i == 1) ? '0 : $urandom);
		end

		// Full list: rejected insert, read beyond the end, clamped remove, pop, shift, then clear.
		send_beat(OP_INSERT, POS_W'(3), $urandom);
		send_beat(OP_READ, '1, '0);
		send_beat(OP_REMOVE, '1, '0);
		send_beat(OP_POP, '0, '0);
		send_beat(OP_SHIFT, '0, '0);
		send_beat(OP_CLEAR, '0, '0);

		// Random traffic in alternating growing and shrinking phases.
		counted = 0;
		growing = 1'b1;
		while (counted < RANDOM_ITEMS) begin
			if (counted % 64 == 0) begin
				growing = !growing;
				idle_on = ($urandom_range(0, 3) != 0);
			end
			calm = (counted >= RANDOM_ITEMS - CALM_TAIL);
			op = pick_op(growing);
			if ($urandom_range(0, 4) != 0)
				pos = POS_W'($urandom_range(0, DEPTH + 1));
			else
				pos = POS_W'($urandom_range(0, 31));
			send_beat(op, pos, random_word());
			if (op != OP_SPARE_LO && op != OP_SPARE_HI)
				counted++;
		end
		in_valid <= 1'b0;

		// Drain the outstanding results, then wait quietly before the verdict.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("tb_top: %0d request beats sent, %0d results compared", sent, compared);
		$display("tb_top: %0d results carried a full, empty or range status", rejects);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
